// ===== src/crd_pkg.sv =====
// crd_pkg: shared constants and types for the camera ray direction block.
// Holds field widths, register indexes and reset values; no dependencies.
package crd_pkg;

    localparam int unsigned CRD_MAX_DIM = 4096;

    localparam int unsigned PIX_W   = 12;
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned AXIS_W  = 48;
    localparam int unsigned TAN_W   = 31;
    localparam int unsigned COMP_W  = 16;
    localparam int unsigned DIR_W   = 16;
    localparam int unsigned PADDR_W = 6;
    localparam int unsigned PDATA_W = 64;

    // Register index, taken from paddr[5:3] (registers lie on 8-byte steps)
    typedef enum logic [2:0] {
        REG_X_AXIS       = 3'd0,
        REG_Y_AXIS       = 3'd1,
        REG_Z_AXIS       = 3'd2,
        REG_TAN_X        = 3'd3,
        REG_TAN_Y        = 3'd4,
        REG_IMAGE_WIDTH  = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6
    } crd_reg_idx_t;

    localparam logic [AXIS_W-1:0] RST_X_AXIS       = 48'd16384;
    localparam logic [AXIS_W-1:0] RST_Y_AXIS       = 48'd1073741824;
    localparam logic [AXIS_W-1:0] RST_Z_AXIS       = 48'd70368744177664;
    localparam logic [TAN_W-1:0]  RST_TAN          = 31'd65536;
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;

    typedef logic signed [COMP_W-1:0] crd_comp_t;

endpackage

// ===== src/crd_div.sv =====
// crd_div: pipelined restoring divider, several lanes side by side.
// SPS quotient bits per stage; a tag word rides along. No dependencies.
module crd_div #(
    parameter int unsigned LANES = 1,
    parameter int unsigned DW    = 8,
    parameter int unsigned QW    = 8,
    parameter int unsigned SPS   = 1,
    parameter int unsigned TW    = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][DW-1:0]   in_hi,   // starting remainder, below divisor
    input  logic [LANES-1:0][QW-1:0]   in_lo,   // low dividend bits
    input  logic [LANES-1:0][DW-1:0]   in_div,
    input  logic [TW-1:0]              in_tag,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   out_quo,
    output logic [TW-1:0]              out_tag
);

    localparam int unsigned STAGES = QW / SPS;

    logic                     valid_reg [STAGES];
    logic [LANES-1:0][DW-1:0] rem_reg   [STAGES];
    logic [LANES-1:0][QW-1:0] word_reg  [STAGES];
    logic [LANES-1:0][DW-1:0] div_reg   [STAGES];
    logic [TW-1:0]            tag_reg   [STAGES];

    logic [LANES-1:0][DW-1:0] rem_next  [STAGES];
    logic [LANES-1:0][QW-1:0] word_next [STAGES];

    always_comb begin
        logic [DW:0]   trial;
        logic [DW-1:0] r;
        logic [DW-1:0] d;
        logic [QW-1:0] w;
        for (int s = 0; s < STAGES; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    r = in_hi[l];
                    w = in_lo[l];
                    d = in_div[l];
                end else begin
                    r = rem_reg[s-1][l];
                    w = word_reg[s-1][l];
                    d = div_reg[s-1][l];
                end
                // shift in the next dividend bit, subtract where it fits
                for (int k = 0; k < SPS; k++) begin
                    trial = {r, w[QW-1]};
                    w     = {w[QW-2:0], 1'b0};
                    if (trial >= {1'b0, d}) begin
                        trial = trial - {1'b0, d};
                        w[0]  = 1'b1;
                    end
                    r = trial[DW-1:0];
                end
                rem_next[s][l]  = r;
                word_next[s][l] = w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STAGES; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < STAGES; s++) begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < STAGES; s++) begin
                rem_reg[s]  <= rem_next[s];
                word_reg[s] <= word_next[s];
                div_reg[s]  <= (s == 0) ? in_div : div_reg[s-1];
                tag_reg[s]  <= (s == 0) ? in_tag : tag_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = word_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

// ===== src/crd_isqrt.sv =====
// crd_isqrt: pipelined integer square root, floor(sqrt(n)) of a 64-bit word.
// Two root bits per stage, 16 stages; a tag word rides along. No dependencies.
module crd_isqrt #(
    parameter int unsigned TW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   in_radicand,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [31:0]   out_root,
    output logic [TW-1:0] out_tag
);

    localparam int unsigned NW     = 64;
    localparam int unsigned RW     = NW / 2;
    localparam int unsigned SPS    = 2;
    localparam int unsigned STAGES = RW / SPS;
    localparam int unsigned REMW   = RW + 2;

    logic            valid_reg [STAGES];
    logic [REMW-1:0] rem_reg   [STAGES];
    logic [RW-1:0]   root_reg  [STAGES];
    logic [NW-1:0]   word_reg  [STAGES];
    logic [TW-1:0]   tag_reg   [STAGES];

    logic [REMW-1:0] rem_next  [STAGES];
    logic [RW-1:0]   root_next [STAGES];
    logic [NW-1:0]   word_next [STAGES];

    always_comb begin
        logic [REMW+1:0] t;
        logic [REMW+1:0] trial;
        logic [REMW-1:0] r;
        logic [RW-1:0]   q;
        logic [NW-1:0]   w;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                r = '0;
                q = '0;
                w = in_radicand;
            end else begin
                r = rem_reg[s-1];
                q = root_reg[s-1];
                w = word_reg[s-1];
            end
            for (int k = 0; k < SPS; k++) begin
                t     = {r, w[NW-1:NW-2]};
                trial = {2'b00, q, 2'b01};
                w     = {w[NW-3:0], 2'b00};
                if (t >= trial) begin
                    t = t - trial;
                    q = {q[RW-2:0], 1'b1};
                end else begin
                    q = {q[RW-2:0], 1'b0};
                end
                r = t[REMW-1:0];
            end
            rem_next[s]  = r;
            root_next[s] = q;
            word_next[s] = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STAGES; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < STAGES; s++) begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < STAGES; s++) begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                word_reg[s] <= word_next[s];
                tag_reg[s]  <= (s == 0) ? in_tag : tag_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = root_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

// ===== src/camera_ray_direction.sv =====
// camera_ray_direction: pinhole camera ray generator, one pixel beat in, one
// unit world direction beat out. Throughput is one beat per cycle while the
// skid register is empty, set by the fully pipelined dividers and root.
// Reset (aresetn low, synchronous) empties the pipeline and loads the camera
// registers with identity axes, unit tangents and a 640 x 480 image.
// Uses crd_pkg, crd_div and crd_isqrt.
module camera_ray_direction #(
    parameter int unsigned MAX_DIM = crd_pkg::CRD_MAX_DIM
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // pixel input: [11:0] pixel_x, [23:12] pixel_y
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,
    // direction output: [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crd_pkg::PADDR_W-1:0]  paddr,
    input  logic [crd_pkg::PDATA_W-1:0]  pwdata,
    output logic [crd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [crd_pkg::AXIS_W-1:0] x_axis_reg;
    logic [crd_pkg::AXIS_W-1:0] y_axis_reg;
    logic [crd_pkg::AXIS_W-1:0] z_axis_reg;
    logic [crd_pkg::TAN_W-1:0]  tan_x_reg;
    logic [crd_pkg::TAN_W-1:0]  tan_y_reg;
    logic [crd_pkg::DIM_W-1:0]  width_reg;
    logic [crd_pkg::DIM_W-1:0]  height_reg;

    crd_pkg::crd_reg_idx_t cfg_idx;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = crd_pkg::crd_reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_axis_reg <= crd_pkg::RST_X_AXIS;
            y_axis_reg <= crd_pkg::RST_Y_AXIS;
            z_axis_reg <= crd_pkg::RST_Z_AXIS;
            tan_x_reg  <= crd_pkg::RST_TAN;
            tan_y_reg  <= crd_pkg::RST_TAN;
            width_reg  <= crd_pkg::RST_IMAGE_WIDTH;
            height_reg <= crd_pkg::RST_IMAGE_HEIGHT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                crd_pkg::REG_X_AXIS:       x_axis_reg <= pwdata[47:0];
                crd_pkg::REG_Y_AXIS:       y_axis_reg <= pwdata[47:0];
                crd_pkg::REG_Z_AXIS:       z_axis_reg <= pwdata[47:0];
                crd_pkg::REG_TAN_X:        tan_x_reg  <= pwdata[30:0];
                crd_pkg::REG_TAN_Y:        tan_y_reg  <= pwdata[30:0];
                crd_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[12:0];
                crd_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            crd_pkg::REG_X_AXIS:       prdata = {16'b0, x_axis_reg};
            crd_pkg::REG_Y_AXIS:       prdata = {16'b0, y_axis_reg};
            crd_pkg::REG_Z_AXIS:       prdata = {16'b0, z_axis_reg};
            crd_pkg::REG_TAN_X:        prdata = {33'b0, tan_x_reg};
            crd_pkg::REG_TAN_Y:        prdata = {33'b0, tan_y_reg};
            crd_pkg::REG_IMAGE_WIDTH:  prdata = {51'b0, width_reg};
            crd_pkg::REG_IMAGE_HEIGHT: prdata = {51'b0, height_reg};
            default:                   prdata = '0;
        endcase
    end

    // Clamp the dimensions into [2, MAX_DIM] and take one off: the
    // span from the first to the last pixel center.
    logic [12:0] dw;
    logic [12:0] dh;

    always_comb begin
        if (width_reg < 13'd2) begin
            dw = 13'd1;
        end else if (32'(width_reg) > 32'(MAX_DIM)) begin
            dw = 13'(MAX_DIM - 1);
        end else begin
            dw = width_reg - 13'd1;
        end
        if (height_reg < 13'd2) begin
            dh = 13'd1;
        end else if (32'(height_reg) > 32'(MAX_DIM)) begin
            dh = 13'(MAX_DIM - 1);
        end else begin
            dh = height_reg - 13'd1;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the skid
    // register holds a beat. The output register plus skid keep taking
    // input while one finished beat waits at m_tdata.
    // ------------------------------------------------------------------
    logic en;
    logic skid_v_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // Stage 1: signed pixel offset from the image center, doubled
    logic              s1_v_reg;
    logic [1:0][12:0]  s1_mag_reg;
    logic [1:0]        s1_neg_reg;
    logic signed [14:0] n_lane [2];
    logic [1:0][12:0]  s1_mag_next;
    logic [1:0]        s1_neg_next;

    always_comb begin
        n_lane[0] = $signed({2'b0, s_tdata[11:0], 1'b0}) - $signed({2'b0, dw});
        n_lane[1] = $signed({2'b0, dh}) - $signed({2'b0, s_tdata[23:12], 1'b0});
        for (int l = 0; l < 2; l++) begin
            s1_neg_next[l] = n_lane[l][14];
            s1_mag_next[l] = n_lane[l][14] ? 13'(-n_lane[l]) : 13'(n_lane[l]);
        end
    end

    // Stage 2: scale by the fov tangent
    logic              s2_v_reg;
    logic [1:0][43:0]  s2_prod_reg;
    logic [1:0]        s2_neg_reg;

    // Stage 3: rounding dividend 2p + d
    logic              s3_v_reg;
    logic [1:0][47:0]  s3_num_reg;
    logic [1:0]        s3_neg_reg;

    // Divide by 2d, four quotient bits a stage
    logic              uv_v;
    logic [1:0][47:0]  uv_quo;
    logic [1:0]        uv_neg;

    crd_div #(
        .LANES (2),
        .DW    (14),
        .QW    (48),
        .SPS   (4),
        .TW    (2)
    ) u_div_uv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_v_reg),
        .in_hi     ('0),
        .in_lo     (s3_num_reg),
        .in_div    ({{dh, 1'b0}, {dw, 1'b0}}),
        .in_tag    (s3_neg_reg),
        .out_valid (uv_v),
        .out_quo   (uv_quo),
        .out_tag   (uv_neg)
    );

    // Stage 4: restore sign, camera-space u and v in Q.16
    logic               s4_v_reg;
    logic signed [45:0] s4_vec_reg [2];

    // Stage 5: rotate into world space, one product per axis term
    logic               s5_v_reg;
    logic signed [61:0] s5_pu_reg [3];
    logic signed [61:0] s5_pv_reg [3];
    logic signed [62:0] s5_pw_reg [3];

    // Stage 6: sum the terms, Q.30 world vector
    logic               s6_v_reg;
    logic signed [62:0] s6_c_reg [3];

    // Stage 7: magnitudes, signs and their OR for the leading one
    logic              s7_v_reg;
    logic [2:0][61:0]  s7_mag_reg;
    logic [2:0]        s7_neg_reg;
    logic [61:0]       s7_or_reg;
    logic [2:0][61:0]  s7_mag_next;
    logic [2:0]        s7_neg_next;

    // Stage 8: leading one, per byte group
    logic              s8_v_reg;
    logic [7:0]        s8_nz_reg;
    logic [7:0][2:0]   s8_idx_reg;
    logic [2:0][61:0]  s8_mag_reg;
    logic [2:0]        s8_neg_reg;
    logic [7:0]        s8_nz_next;
    logic [7:0][2:0]   s8_idx_next;

    // Stage 9: leading one over the groups
    logic              s9_v_reg;
    logic [5:0]        s9_msb_reg;
    logic              s9_zero_reg;
    logic [2:0][61:0]  s9_mag_reg;
    logic [2:0]        s9_neg_reg;
    logic [5:0]        s9_msb_next;

    // Stage 10: common shift, largest magnitude into [2^30, 2^31)
    logic              s10_v_reg;
    logic [2:0][30:0]  s10_norm_reg;
    logic [2:0]        s10_neg_reg;
    logic              s10_zero_reg;
    logic [2:0][30:0]  s10_norm_next;

    // Stage 11: squares
    logic              s11_v_reg;
    logic [2:0][61:0]  s11_sq_reg;
    logic [2:0][30:0]  s11_norm_reg;
    logic [2:0]        s11_neg_reg;
    logic              s11_zero_reg;

    // Stage 12: sum of squares
    logic              s12_v_reg;
    logic [63:0]       s12_sum_reg;
    logic [2:0][30:0]  s12_norm_reg;
    logic [2:0]        s12_neg_reg;
    logic              s12_zero_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s7_neg_next[i] = s6_c_reg[i][62];
            s7_mag_next[i] = s6_c_reg[i][62] ? 62'(-s6_c_reg[i]) : 62'(s6_c_reg[i]);
        end
    end

    always_comb begin
        logic [63:0] or_pad;
        or_pad = {2'b0, s7_or_reg};
        for (int g = 0; g < 8; g++) begin
            s8_nz_next[g]  = |or_pad[8*g +: 8];
            s8_idx_next[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (or_pad[8*g + b]) begin
                    s8_idx_next[g] = 3'(b);
                end
            end
        end
        s9_msb_next = 6'd0;
        for (int g = 0; g < 8; g++) begin
            if (s8_nz_reg[g]) begin
                s9_msb_next = {3'(g), s8_idx_reg[g]};
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (s9_msb_reg >= 6'd30) begin
                s10_norm_next[i] = 31'(s9_mag_reg[i] >> (s9_msb_reg - 6'd30));
            end else begin
                s10_norm_next[i] = 31'(s9_mag_reg[i] << (6'd30 - s9_msb_reg));
            end
        end
    end

    // Length: floor of the root of the sum of squares
    logic              rt_v;
    logic [31:0]       rt_len;
    logic [96:0]       rt_tag;

    crd_isqrt #(
        .TW (97)
    ) u_isqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s12_v_reg),
        .in_radicand (s12_sum_reg),
        .in_tag      ({s12_zero_reg, s12_neg_reg, s12_norm_reg}),
        .out_valid   (rt_v),
        .out_root    (rt_len),
        .out_tag     (rt_tag)
    );

    // Stage 13: rounding dividend (|c| << 15) + len/2
    logic              s13_v_reg;
    logic [2:0][46:0]  s13_num_reg;
    logic [31:0]       s13_len_reg;
    logic [2:0]        s13_neg_reg;
    logic              s13_zero_reg;
    logic [2:0][30:0]  rt_norm;
    logic [2:0][31:0]  q_hi;
    logic [2:0][15:0]  q_lo;

    assign rt_norm = rt_tag[92:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_hi[i] = {1'b0, s13_num_reg[i][46:16]};
            q_lo[i] = s13_num_reg[i][15:0];
        end
    end

    // Divide each component by the length, two quotient bits a stage
    logic              qd_v;
    logic [2:0][15:0]  qd_quo;
    logic [3:0]        qd_tag;

    crd_div #(
        .LANES (3),
        .DW    (32),
        .QW    (16),
        .SPS   (2),
        .TW    (4)
    ) u_div_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s13_v_reg),
        .in_hi     (q_hi),
        .in_lo     (q_lo),
        .in_div    ({s13_len_reg, s13_len_reg, s13_len_reg}),
        .in_tag    ({s13_zero_reg, s13_neg_reg}),
        .out_valid (qd_v),
        .out_quo   (qd_quo),
        .out_tag   (qd_tag)
    );

    // Stage 14: restore sign and saturate to Q1.15; a zero vector gives zeros
    logic              s14_v_reg;
    logic [47:0]       s14_dir_reg;
    logic [47:0]       s14_dir_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (qd_tag[3]) begin
                s14_dir_next[16*i +: 16] = 16'd0;
            end else if (qd_tag[i]) begin
                s14_dir_next[16*i +: 16] = (qd_quo[i] > 16'd32768) ? 16'h8000 : 16'(-qd_quo[i]);
            end else begin
                s14_dir_next[16*i +: 16] = (qd_quo[i] > 16'd32767) ? 16'h7fff : qd_quo[i];
            end
        end
    end

    // Valid bits: advance with the pipeline, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
            s12_v_reg <= 1'b0;
            s13_v_reg <= 1'b0;
            s14_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg  <= s_tvalid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= uv_v;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= s10_v_reg;
            s12_v_reg <= s11_v_reg;
            s13_v_reg <= rt_v;
            s14_v_reg <= qd_v;
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mag_reg <= s1_mag_next;
            s1_neg_reg <= s1_neg_next;

            s2_prod_reg[0] <= tan_x_reg * s1_mag_reg[0];
            s2_prod_reg[1] <= tan_y_reg * s1_mag_reg[1];
            s2_neg_reg     <= s1_neg_reg;

            s3_num_reg[0] <= {3'b0, s2_prod_reg[0], 1'b0} + {35'b0, dw};
            s3_num_reg[1] <= {3'b0, s2_prod_reg[1], 1'b0} + {35'b0, dh};
            s3_neg_reg    <= s2_neg_reg;

            for (int l = 0; l < 2; l++) begin
                s4_vec_reg[l] <= uv_neg[l] ? -$signed({1'b0, uv_quo[l][44:0]})
                                           : $signed({1'b0, uv_quo[l][44:0]});
            end

            for (int i = 0; i < 3; i++) begin
                s5_pu_reg[i] <= s4_vec_reg[0] * crd_pkg::crd_comp_t'(x_axis_reg[16*i +: 16]);
                s5_pv_reg[i] <= s4_vec_reg[1] * crd_pkg::crd_comp_t'(y_axis_reg[16*i +: 16]);
                s5_pw_reg[i] <= -(63'(crd_pkg::crd_comp_t'(z_axis_reg[16*i +: 16])) <<< 16);
            end

            for (int i = 0; i < 3; i++) begin
                s6_c_reg[i] <= 63'(s5_pu_reg[i]) + 63'(s5_pv_reg[i]) + s5_pw_reg[i];
            end

            s7_mag_reg <= s7_mag_next;
            s7_neg_reg <= s7_neg_next;
            s7_or_reg  <= s7_mag_next[0] | s7_mag_next[1] | s7_mag_next[2];

            s8_nz_reg  <= s8_nz_next;
            s8_idx_reg <= s8_idx_next;
            s8_mag_reg <= s7_mag_reg;
            s8_neg_reg <= s7_neg_reg;

            s9_msb_reg  <= s9_msb_next;
            s9_zero_reg <= ~|s8_nz_reg;
            s9_mag_reg  <= s8_mag_reg;
            s9_neg_reg  <= s8_neg_reg;

            s10_norm_reg <= s10_norm_next;
            s10_neg_reg  <= s9_neg_reg;
            s10_zero_reg <= s9_zero_reg;

            for (int i = 0; i < 3; i++) begin
                s11_sq_reg[i] <= s10_norm_reg[i] * s10_norm_reg[i];
            end
            s11_norm_reg <= s10_norm_reg;
            s11_neg_reg  <= s10_neg_reg;
            s11_zero_reg <= s10_zero_reg;

            s12_sum_reg  <= {2'b0, s11_sq_reg[0]} + {2'b0, s11_sq_reg[1]}
                          + {2'b0, s11_sq_reg[2]};
            s12_norm_reg <= s11_norm_reg;
            s12_neg_reg  <= s11_neg_reg;
            s12_zero_reg <= s11_zero_reg;

            for (int i = 0; i < 3; i++) begin
                s13_num_reg[i] <= {1'b0, rt_norm[i], 15'b0} + {16'b0, rt_len[31:1]};
            end
            s13_len_reg  <= rt_len;
            s13_neg_reg  <= rt_tag[95:93];
            s13_zero_reg <= rt_tag[96];

            s14_dir_reg <= s14_dir_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid: the skid catches the beat leaving the
    // pipeline while the output beat stalls, then freezes the pipeline.
    // ------------------------------------------------------------------
    logic        out_v_reg;
    logic [47:0] out_d_reg;
    logic [47:0] skid_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_tready) begin
                skid_v_reg <= 1'b0;
            end
        end else if (!out_v_reg || m_tready) begin
            out_v_reg <= s14_v_reg;
        end else if (s14_v_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_tready) begin
                out_d_reg <= skid_d_reg;
            end
        end else if (!out_v_reg || m_tready) begin
            out_d_reg <= s14_dir_reg;
        end else begin
            skid_d_reg <= s14_dir_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

endmodule
